// ===== rtl/pesh_pkg.sv =====
// Shared types, status codes and timestamp helpers for the PES header parser.
package pesh_pkg;

    // Verdict codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MORE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // How far the header got when a verdict is given
    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_ID    = 2'd1;
    localparam logic [1:0] PH_FLAGS = 2'd2;

    // Stream ids that carry no optional header
    localparam logic [7:0] SID_PROGRAM_MAP = 8'hBC;
    localparam logic [7:0] SID_PADDING     = 8'hBE;
    localparam logic [7:0] SID_PRIVATE_2   = 8'hBF;

    // Byte positions within the header
    localparam logic [8:0] IDX_SC0     = 9'd0;
    localparam logic [8:0] IDX_SC1     = 9'd1;
    localparam logic [8:0] IDX_SC2     = 9'd2;
    localparam logic [8:0] IDX_SID     = 9'd3;
    localparam logic [8:0] IDX_LEN_HI  = 9'd4;
    localparam logic [8:0] IDX_LEN_LO  = 9'd5;
    localparam logic [8:0] IDX_FLAGS1  = 9'd6;
    localparam logic [8:0] IDX_FLAGS2  = 9'd7;
    localparam logic [8:0] IDX_HDL     = 9'd8;
    localparam logic [8:0] IDX_PTS0    = 9'd9;
    localparam logic [8:0] IDX_PTS4    = 9'd13;
    localparam logic [8:0] IDX_DTS0    = 9'd14;
    localparam logic [8:0] IDX_DTS4    = 9'd18;
    localparam logic [8:0] IDX_MAX     = 9'd511;

    localparam logic [8:0] SIZE_SHORT  = 9'd6;
    localparam logic [8:0] SIZE_FIXED  = 9'd9;
    localparam logic [7:0] HDL_PTS_MIN = 8'd5;
    localparam logic [7:0] HDL_DTS_MIN = 8'd10;

    localparam logic [1:0] PTSDTS_BOTH = 2'b11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    // Input register contents handed to the parser core
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic [1:0]  result_status;
        logic [7:0]  stream_code;
        logic [15:0] packet_length;
        logic [5:0]  basic_flags;
        logic [7:0]  extra_flags;
        logic [7:0]  header_data_length;
        logic [32:0] pts_value;
        logic [32:0] dts_value;
        logic [8:0]  header_size;
    } result_t;

    // Place one timestamp byte into the 33-bit value, marker bits dropped
    function automatic logic [32:0] ts_piece(input logic [2:0] pos, input logic [7:0] d);
        logic [32:0] v;
        begin
            case (pos)
                3'd0:    v = {d[3:1], 30'd0};
                3'd1:    v = {3'd0, d, 22'd0};
                3'd2:    v = {11'd0, d[7:1], 15'd0};
                3'd3:    v = {18'd0, d, 7'd0};
                3'd4:    v = {26'd0, d[7:1]};
                default: v = 33'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/pesh_in_if.sv =====
// Byte channel into the PES header parser.
interface pesh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

// ===== rtl/pesh_out_if.sv =====
// Verdict channel out of the PES header parser.
interface pesh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_status;
    logic [7:0]  stream_code;
    logic [15:0] packet_length;
    logic [5:0]  basic_flags;
    logic [7:0]  extra_flags;
    logic [7:0]  header_data_length;
    logic [32:0] pts_value;
    logic [32:0] dts_value;
    logic [8:0]  header_size;

    modport source (output valid, output result_status, output stream_code,
                    output packet_length, output basic_flags, output extra_flags,
                    output header_data_length, output pts_value, output dts_value,
                    output header_size, input ready);
    modport sink   (input valid, input result_status, input stream_code,
                    input packet_length, input basic_flags, input extra_flags,
                    input header_data_length, input pts_value, input dts_value,
                    input header_size, output ready);
endinterface

// ===== rtl/pesh_in_stage.sv =====
// Input register that holds one byte item for the parser core.
module pesh_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    pesh_in_if.sink              bytes,
    input  logic                 advance,
    output pesh_pkg::stage_t     stage
);

    logic            valid_reg;
    pesh_pkg::item_t item_reg;
    logic            take;

    // Accept when empty or when the core consumes the held item
    assign bytes.ready = !valid_reg || advance;
    assign take        = bytes.valid && bytes.ready;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte  <= bytes.data_byte;
            item_reg.first_byte <= bytes.first_byte;
            item_reg.last_byte  <= bytes.last_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ===== rtl/pesh_core.sv =====
// Header field capture, verdict logic and result register of the PES parser.
module pesh_core (
    input  logic             clk,
    input  logic             rst_n,
    input  pesh_pkg::stage_t stage,
    output logic             advance,
    pesh_out_if.source       verdict
);

    // Parser state
    logic [8:0]  byte_index_reg;
    logic        verdict_given_reg;
    logic        start_good_reg;
    logic        marker_good_reg;
    logic [7:0]  sid_reg;
    logic [15:0] length_reg;
    logic [5:0]  basic_reg;
    logic [7:0]  extra_reg;
    logic [7:0]  hdl_reg;
    logic [32:0] pts_reg;
    logic [32:0] dts_reg;

    logic [8:0]  byte_index_next;
    logic        start_good_next;
    logic        marker_good_next;
    logic [7:0]  sid_next;
    logic [15:0] length_next;
    logic [5:0]  basic_next;
    logic [7:0]  extra_next;
    logic [7:0]  hdl_next;
    logic [32:0] pts_next;
    logic [32:0] dts_next;

    // Result register
    logic              out_valid_reg;
    pesh_pkg::result_t out_reg;
    pesh_pkg::result_t res;

    logic        fb;
    logic [7:0]  d;
    logic        active;
    logic        found;
    logic [1:0]  status;
    logic [1:0]  phase;
    logic [1:0]  ptsdts;
    logic [8:0]  k;
    logic [8:0]  end_index;
    logic [8:0]  hsize;
    logic [32:0] pts_o;
    logic [32:0] dts_o;
    logic [2:0]  pts_pos;
    logic [2:0]  dts_pos;
    logic        consume;

    assign advance = !out_valid_reg || verdict.ready;
    assign consume = stage.valid && advance;
    assign fb      = stage.item.first_byte;
    assign d       = stage.item.data_byte;
    assign active  = fb || !verdict_given_reg;

    // Update fields for this byte, starting from cleared state on a first byte
    always_comb
    begin
        k                = fb ? 9'd0 : byte_index_reg;
        start_good_next  = fb ? 1'b1 : start_good_reg;
        marker_good_next = fb ? 1'b1 : marker_good_reg;
        sid_next         = fb ? 8'd0 : sid_reg;
        length_next      = fb ? 16'd0 : length_reg;
        basic_next       = fb ? 6'd0 : basic_reg;
        extra_next       = fb ? 8'd0 : extra_reg;
        hdl_next         = fb ? 8'd0 : hdl_reg;
        pts_next         = fb ? 33'd0 : pts_reg;
        dts_next         = fb ? 33'd0 : dts_reg;
        pts_pos          = 3'(k - pesh_pkg::IDX_PTS0);
        dts_pos          = 3'(k - pesh_pkg::IDX_DTS0);
        ptsdts           = extra_next[7:6];

        if (k == pesh_pkg::IDX_SC0 || k == pesh_pkg::IDX_SC1)
        begin
            start_good_next = start_good_next && (d == 8'h00);
        end
        else if (k == pesh_pkg::IDX_SC2)
        begin
            start_good_next = start_good_next && (d == 8'h01);
        end
        else if (k == pesh_pkg::IDX_SID)
        begin
            sid_next = d;
        end
        else if (k == pesh_pkg::IDX_LEN_HI)
        begin
            length_next = {d, 8'd0};
        end
        else if (k == pesh_pkg::IDX_LEN_LO)
        begin
            length_next = {length_next[15:8], d};
        end
        else if (k == pesh_pkg::IDX_FLAGS1)
        begin
            marker_good_next = (d[7:6] == 2'b10);
            basic_next       = d[5:0];
        end
        else if (k == pesh_pkg::IDX_FLAGS2)
        begin
            extra_next = d;
        end
        else if (k == pesh_pkg::IDX_HDL)
        begin
            hdl_next = d;
        end
        else if (k >= pesh_pkg::IDX_PTS0 && k <= pesh_pkg::IDX_PTS4)
        begin
            if (ptsdts[1])
            begin
                pts_next = pts_next | pesh_pkg::ts_piece(pts_pos, d);
            end
        end
        else if (k >= pesh_pkg::IDX_DTS0 && k <= pesh_pkg::IDX_DTS4)
        begin
            if (ptsdts == pesh_pkg::PTSDTS_BOTH)
            begin
                dts_next = dts_next | pesh_pkg::ts_piece(dts_pos, d);
            end
        end

        byte_index_next = (k < pesh_pkg::IDX_MAX) ? k + 9'd1 : k;
    end

    // Decide the verdict for this byte
    always_comb
    begin
        found     = 1'b0;
        status    = pesh_pkg::ST_OK;
        phase     = pesh_pkg::PH_NONE;
        hsize     = 9'd0;
        pts_o     = 33'd0;
        dts_o     = 33'd0;
        end_index = {1'b0, hdl_next} + pesh_pkg::IDX_HDL;

        if (k == pesh_pkg::IDX_LEN_LO)
        begin
            if (!start_good_next)
            begin
                found  = 1'b1;
                status = pesh_pkg::ST_BAD;
                phase  = pesh_pkg::PH_NONE;
            end
            else if (sid_next inside {pesh_pkg::SID_PROGRAM_MAP, pesh_pkg::SID_PADDING,
                                      pesh_pkg::SID_PRIVATE_2})
            begin
                found  = 1'b1;
                status = pesh_pkg::ST_OK;
                phase  = pesh_pkg::PH_ID;
                hsize  = pesh_pkg::SIZE_SHORT;
            end
        end

        if (!found && k == pesh_pkg::IDX_HDL && !marker_good_next)
        begin
            found  = 1'b1;
            status = pesh_pkg::ST_BAD;
            phase  = pesh_pkg::PH_ID;
        end

        if (!found && k == end_index)
        begin
            found = 1'b1;
            phase = pesh_pkg::PH_FLAGS;
            if ((ptsdts[1] && hdl_next < pesh_pkg::HDL_PTS_MIN) ||
                (ptsdts == pesh_pkg::PTSDTS_BOTH && hdl_next < pesh_pkg::HDL_DTS_MIN))
            begin
                status = pesh_pkg::ST_BAD;
            end
            else
            begin
                status = pesh_pkg::ST_OK;
                hsize  = {1'b0, hdl_next} + pesh_pkg::SIZE_FIXED;
                pts_o  = ptsdts[1] ? pts_next : 33'd0;
                dts_o  = (ptsdts == pesh_pkg::PTSDTS_BOTH) ? dts_next : pts_o;
            end
        end

        // Out of data with no verdict yet
        if (!found && stage.item.last_byte)
        begin
            found  = 1'b1;
            status = pesh_pkg::ST_MORE;
            if (k < pesh_pkg::IDX_LEN_LO)
            begin
                phase = pesh_pkg::PH_NONE;
            end
            else if (k < pesh_pkg::IDX_HDL)
            begin
                phase = pesh_pkg::PH_ID;
            end
            else
            begin
                phase = pesh_pkg::PH_FLAGS;
            end
        end
    end

    // Mask the result fields by how far the header got
    always_comb
    begin
        res.result_status      = status;
        res.stream_code        = (phase != pesh_pkg::PH_NONE) ? sid_next : 8'd0;
        res.packet_length      = (phase != pesh_pkg::PH_NONE) ? length_next : 16'd0;
        res.basic_flags        = (phase == pesh_pkg::PH_FLAGS) ? basic_next : 6'd0;
        res.extra_flags        = (phase == pesh_pkg::PH_FLAGS) ? extra_next : 8'd0;
        res.header_data_length = (phase == pesh_pkg::PH_FLAGS) ? hdl_next : 8'd0;
        res.pts_value          = pts_o;
        res.dts_value          = dts_o;
        res.header_size        = hsize;
    end

    // Advance parser state on each consumed byte of a live packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= 9'd0;
            verdict_given_reg <= 1'b1;
            start_good_reg    <= 1'b1;
            marker_good_reg   <= 1'b1;
            sid_reg           <= 8'd0;
            length_reg        <= 16'd0;
            basic_reg         <= 6'd0;
            extra_reg         <= 8'd0;
            hdl_reg           <= 8'd0;
            pts_reg           <= 33'd0;
            dts_reg           <= 33'd0;
        end
        else if (consume && active)
        begin
            byte_index_reg    <= byte_index_next;
            verdict_given_reg <= found;
            start_good_reg    <= start_good_next;
            marker_good_reg   <= marker_good_next;
            sid_reg           <= sid_next;
            length_reg        <= length_next;
            basic_reg         <= basic_next;
            extra_reg         <= extra_next;
            hdl_reg           <= hdl_next;
            pts_reg           <= pts_next;
            dts_reg           <= dts_next;
        end
    end

    // Hold the result valid flag until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage.valid && active && found;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (consume && active && found)
        begin
            out_reg <= res;
        end
    end

    assign verdict.valid              = out_valid_reg;
    assign verdict.result_status      = out_reg.result_status;
    assign verdict.stream_code        = out_reg.stream_code;
    assign verdict.packet_length      = out_reg.packet_length;
    assign verdict.basic_flags        = out_reg.basic_flags;
    assign verdict.extra_flags        = out_reg.extra_flags;
    assign verdict.header_data_length = out_reg.header_data_length;
    assign verdict.pts_value          = out_reg.pts_value;
    assign verdict.dts_value          = out_reg.dts_value;
    assign verdict.header_size        = out_reg.header_size;

endmodule

// ===== rtl/pes_header_parser.sv =====
// PES header parser: takes one packet byte per cycle unless stalled; one verdict per packet.
// The parser accepts one byte item every clock cycle while the result side is not
// stalled; the byte that decides a verdict is held in the input register, then the
// verdict is loaded into the result register and presented on the result channel.
// The rate is set by the field capture and verdict compare against the byte counter,
// which are combinational. A stall on the result side holds the result register; one
// more byte can still enter the input register, and once that register is full ready
// on the byte side drops in the same cycle. Bytes that arrive after a verdict, or
// before any first byte, are consumed and give no result.
module pes_header_parser (
    input  logic       clk,
    input  logic       rst_n,
    pesh_in_if.sink    bytes,
    pesh_out_if.source verdict
);

    pesh_pkg::stage_t stage;
    logic             advance;

    pesh_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (advance),
        .stage   (stage)
    );

    pesh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .verdict (verdict)
    );

`ifndef SYNTH
    // Status is never the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> (verdict.result_status == pesh_pkg::ST_OK ||
                           verdict.result_status == pesh_pkg::ST_MORE ||
                           verdict.result_status == pesh_pkg::ST_BAD))
        else $error("result status out of range");

    // Only an ok verdict carries a size or timestamps
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.result_status != pesh_pkg::ST_OK) |->
            (verdict.header_size == 9'd0 && verdict.pts_value == 33'd0 &&
             verdict.dts_value == 33'd0))
        else $error("non-ok verdict carries header size or timestamps");

    // An ok verdict has the short size or the fixed size plus data length
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.result_status == pesh_pkg::ST_OK) |->
            (verdict.header_size == pesh_pkg::SIZE_SHORT ||
             verdict.header_size ==
                 ({1'b0, verdict.header_data_length} + pesh_pkg::SIZE_FIXED)))
        else $error("ok verdict with inconsistent header size");

    // A stalled result is not dropped before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && !verdict.ready) |=> verdict.valid)
        else $error("result dropped while stalled");
`endif

endmodule
